// ===== src/chm_pkg.sv =====
// Package for the chunked 64-bit string hash: shared types and constants.
// Used by every module of the block; depends on nothing.
`default_nettype none

package chm_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    // Odd multiplier used by the per-word multiply and by the final scramble.
    localparam logic [WORD_W-1:0] HASH_MULT = 64'h3C79_AC49_2BA7_B653;

    localparam int unsigned ROT_AMT  = 21;
    localparam int unsigned MIX2_SHR = 7;
    localparam int unsigned MIX2_SHL = 9;

    // What the back end has to do with one queued word.
    typedef enum logic [1:0] {
        OP_EMPTY = 2'd0,
        OP_START = 2'd1,
        OP_CONT  = 2'd2
    } chm_op_t;

    typedef struct packed {
        chm_op_t           op;
        logic              last;
        logic [WORD_W-1:0] spread;
    } chm_entry_t;

    // Sequencer states of the back end.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_MIX    = 3'd1,
        ST_FIN_GO = 3'd2,
        ST_FIN    = 3'd3,
        ST_EMIT   = 3'd4
    } chm_state_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
    } chm_mul_ctl_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] result;
    } chm_mul_stat_t;

endpackage

`default_nettype wire

// ===== src/chunked_string_hash64.sv =====
// Top level of the chunked 64-bit string hash.
// Depends on chm_pkg, chm_front, chm_queue, chm_mul and chm_back.
`default_nettype none

// The block hashes a byte string that arrives as 64-bit little-endian words,
// tail word first (marked by first_chunk) and the word at offset zero last
// (marked by last_chunk); the transfer of the last word yields one result
// transfer carrying hash_value, and a transfer with empty_string set yields a
// hash of zero and clears the running value. The front end classifies each
// input transfer and applies the rotate-xor spread, then parks it in a short
// queue, so input transfers keep being taken while the back end works and the
// queue has room. The back end shares one 32x32 multiplier, used three times
// per 64-bit product, for both the per-word multiply and the final scramble;
// that shared multiplier sets the sustained rate. A finished result sits in an
// output register, so the back end goes on with the next word while the result
// waits to be taken.

module chunked_string_hash64 #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] chunk_word,
    input  wire logic        first_chunk,
    input  wire logic        last_chunk,
    input  wire logic        empty_string,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      hash_value
);
    import chm_pkg::*;

    logic          q_full;
    logic          q_push;
    chm_entry_t    q_push_entry;
    logic          q_valid;
    logic          q_pop;
    chm_entry_t    q_head;
    chm_mul_ctl_t  mul_ctl;
    chm_mul_stat_t mul_stat;

    chm_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .chunk_word   (chunk_word),
        .first_chunk  (first_chunk),
        .last_chunk   (last_chunk),
        .empty_string (empty_string),
        .q_full       (q_full),
        .push         (q_push),
        .push_entry   (q_push_entry)
    );

    chm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head_entry (q_head)
    );

    chm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .stat  (mul_stat)
    );

    chm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_head),
        .q_pop      (q_pop),
        .mul_ctl    (mul_ctl),
        .mul_stat   (mul_stat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    // The back end only starts a product when the multiplier is free.
    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_ctl.start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // A started product keeps the multiplier busy in the next cycle.
    a_mul_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mul_ctl.start |=> mul_stat.busy)
        else $error("multiplier did not take the start");

    // Words leave the queue only when one is present.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== src/chm_queue.sv =====
// Small FIFO of classified words between the front and the back end.
// Depends on chm_pkg for the entry type.
`default_nettype none

module chm_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  chm_pkg::chm_entry_t     push_entry,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output chm_pkg::chm_entry_t     head_entry
);
    import chm_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    chm_entry_t       entry_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign valid      = (count_reg != '0);
    assign head_entry = entry_mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/chm_front.sv =====
// Front end: takes input transfers, classifies them and spreads the word.
// Depends on chm_pkg; feeds chm_queue.
`default_nettype none

module chm_front (
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [63:0]            chunk_word,
    input  wire logic                   first_chunk,
    input  wire logic                   last_chunk,
    input  wire logic                   empty_string,
    input  wire logic                   q_full,
    output logic                        push,
    output chm_pkg::chm_entry_t         push_entry
);
    import chm_pkg::*;

    logic [WORD_W-1:0] rot_l;
    logic [WORD_W-1:0] rot_r;

    assign rot_l = (chunk_word << ROT_AMT) | (chunk_word >> (WORD_W - ROT_AMT));
    assign rot_r = (chunk_word >> ROT_AMT) | (chunk_word << (WORD_W - ROT_AMT));

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_entry.spread = chunk_word ^ rot_l ^ rot_r;
        push_entry.last   = last_chunk;
        priority if (empty_string)
        begin
            push_entry.op = OP_EMPTY;
        end
        else if (first_chunk)
        begin
            push_entry.op = OP_START;
        end
        else
        begin
            push_entry.op = OP_CONT;
        end
    end

endmodule

`default_nettype wire

// ===== src/chm_mul.sv =====
// Iterative multiplier: low 64 bits of operand times the hash constant,
// built from three 32x32 partial products. Depends on chm_pkg.
`default_nettype none

module chm_mul (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  chm_pkg::chm_mul_ctl_t   ctl,
    output chm_pkg::chm_mul_stat_t  stat
);
    import chm_pkg::*;

    localparam logic [1:0] PH_LO       = 2'd0;
    localparam logic [1:0] PH_CROSS_HI = 2'd1;
    localparam logic [1:0] PH_CROSS_LO = 2'd2;
    localparam logic [1:0] PH_SUM      = 2'd3;

    localparam logic [HALF_W-1:0] MULT_LO = HASH_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MULT_HI = HASH_MULT[WORD_W-1:HALF_W];

    logic              busy_reg;
    logic              done_reg;
    logic [1:0]        phase_reg;
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] res_reg;
    logic [HALF_W-1:0] mul_x;
    logic [HALF_W-1:0] mul_y;
    logic [WORD_W-1:0] prod;

    // One 32x32 multiplier; the operand halves are picked by phase.
    assign mul_x = (phase_reg == PH_CROSS_HI) ? a_reg[WORD_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign mul_y = (phase_reg == PH_CROSS_LO) ? MULT_HI : MULT_LO;
    assign prod  = {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};

    assign stat.busy   = busy_reg;
    assign stat.done   = done_reg;
    assign stat.result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= PH_LO;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_LO;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 1'b1;
                if (phase_reg == PH_SUM)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg)
        begin
            a_reg <= ctl.operand;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod;
            unique case (phase_reg)
                PH_LO:
                begin
                end
                PH_CROSS_HI:
                begin
                    res_reg <= prod_reg;
                end
                PH_CROSS_LO, PH_SUM:
                begin
                    res_reg[WORD_W-1:HALF_W] <= res_reg[WORD_W-1:HALF_W] + prod_reg[HALF_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/chm_back.sv =====
// Back end: sequences the hash recurrence and the final scramble, and holds
// the output register. Depends on chm_pkg; drives chm_mul.
`default_nettype none

module chm_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  chm_pkg::chm_entry_t     q_entry,
    output logic                    q_pop,
    output chm_pkg::chm_mul_ctl_t   mul_ctl,
    input  chm_pkg::chm_mul_stat_t  mul_stat,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [63:0]             hash_value
);
    import chm_pkg::*;

    chm_state_t        state_reg, state_next;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] pend_reg;
    logic [WORD_W-1:0] hash_reg;
    logic              out_valid_reg;
    logic              first_reg;
    logic              last_reg;
    logic              slot_free;
    logic              emit_load;
    logic [WORD_W-1:0] acc_mixed;
    logic [WORD_W-1:0] acc_swapped;
    logic [WORD_W-1:0] xs_a;
    logic [WORD_W-1:0] xs_b;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

    // Xor-shift of the running value, right first and then left.
    assign xs_a      = acc_reg ^ (acc_reg >> MIX2_SHR);
    assign xs_b      = xs_a ^ (xs_a << MIX2_SHL);
    assign acc_mixed = xs_b + mul_stat.result;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            acc_swapped[8*k +: 8] = acc_reg[8*(7-k) +: 8];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = (q_entry.op == OP_EMPTY) ? ST_EMIT : ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (mul_stat.done)
                begin
                    state_next = last_reg ? ST_FIN_GO : ST_IDLE;
                end
            end
            ST_FIN_GO:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        q_pop           = 1'b0;
        mul_ctl.start   = 1'b0;
        mul_ctl.operand = q_entry.spread;
        emit_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop         = q_valid;
                mul_ctl.start = q_valid && (q_entry.op != OP_EMPTY);
            end
            ST_FIN_GO:
            begin
                mul_ctl.start   = 1'b1;
                mul_ctl.operand = acc_swapped;
            end
            ST_EMIT:
            begin
                emit_load = slot_free;
            end
            ST_MIX, ST_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && q_valid && q_entry.op == OP_EMPTY)
            begin
                acc_reg <= '0;
            end
            else if (state_reg == ST_MIX && mul_stat.done)
            begin
                acc_reg <= first_reg ? mul_stat.result : acc_mixed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            first_reg <= (q_entry.op == OP_START);
            last_reg  <= q_entry.last;
            pend_reg  <= '0;
        end
        else if (state_reg == ST_FIN && mul_stat.done)
        begin
            pend_reg <= mul_stat.result;
        end
        if (emit_load)
        begin
            hash_reg <= pend_reg;
        end
    end

endmodule

`default_nettype wire
